[design/sqrd_pkg.sv]
// Shared constants for the shortest-queue request dispatcher.
// Holds status codes, field widths, bus widths and parameter defaults.
// No dependencies.
`default_nettype none

package sqrd_pkg;

  // Parameter defaults
  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_WIDTH_DEF    = 16;

  // Request and result field widths
  localparam int MODE_W   = 1;
  localparam int REQ_W    = 16;
  localparam int SEL_W    = 2;
  localparam int STATUS_W = 3;
  localparam int QIDX_W   = 2;
  localparam int REM_W    = 5;

  // Stream bus widths (fields packed from bit 0, tdata padded to bytes)
  localparam int S_TDATA_W = 24;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 3;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int QIU_W   = 3;
  localparam logic [QIU_W-1:0] QIU_RESET = 3'd4;
  localparam logic REG_QUEUES_IN_USE = 1'b0;

  // Request mode
  localparam logic MODE_ENQUEUE = 1'b0;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_ENQUEUED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DEQUEUED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ALL_FULL  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_QUEUE = 3'd4;

endpackage

`default_nettype wire

[design/sqrd_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// Used for the shared entry store. No dependencies.
`default_nettype none

module sqrd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write when enabled with we_i set, register read data on an enabled read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/sqrd_pick.sv]
// Shortest-queue selection: a compare tree over the per-queue entry counts.
// Lowest index wins a tie; inactive and full queues win only when all look full.
// Depends on sqrd_pkg.
`default_nettype none

module sqrd_pick #(
  parameter int NUM_QUEUES  = sqrd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqrd_pkg::QUEUE_DEPTH_DEF,
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1),
  localparam int QW    = $clog2(NUM_QUEUES)
) (
  input  wire logic [NUM_QUEUES-1:0][CNT_W-1:0] count_i,
  input  wire logic [sqrd_pkg::QIU_W-1:0]       queues_in_use_i,
  output logic      [QW-1:0]                    pick_o,
  output logic                                  all_full_o
);

  localparam int LEAVES = 2 ** QW;
  localparam int NODES  = 2 * LEAVES - 1;
  localparam logic [CNT_W-1:0] FULL_KEY = CNT_W'(QUEUE_DEPTH);

  logic [CNT_W-1:0] key_w [NODES];
  logic [QW-1:0]    idx_w [NODES];

  // Load leaves: inactive queues and padding look full
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < NUM_QUEUES) begin : g_real
      assign key_w[LEAVES-1+i] = (32'(queues_in_use_i) > i) ? count_i[i] : FULL_KEY;
    end else begin : g_pad
      assign key_w[LEAVES-1+i] = FULL_KEY;
    end
    assign idx_w[LEAVES-1+i] = QW'(i);
  end

  // Reduce: left subtree holds the lower indices and keeps ties
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    assign key_w[n] = (key_w[2*n+1] <= key_w[2*n+2]) ? key_w[2*n+1] : key_w[2*n+2];
    assign idx_w[n] = (key_w[2*n+1] <= key_w[2*n+2]) ? idx_w[2*n+1] : idx_w[2*n+2];
  end

  assign pick_o     = idx_w[0];
  assign all_full_o = (key_w[0] >= FULL_KEY);

endmodule

`default_nettype wire

[design/shortest_queue_request_dispatcher.sv]
// Shortest-queue request dispatcher: per-queue FIFOs in one shared entry RAM.
// Results pass the pend and output registers; a dequeue first waits in ST_READ
// for the entry RAM read. One request per cycle while the result path is not
// stalled, but a dequeue holds off new requests until its RAM read data returns.
// Reset clears head/tail pointers and counts and sets queues_in_use to 4;
// the entry RAM is not cleared, and requests are taken right after reset.
`default_nettype none

module shortest_queue_request_dispatcher #(
  parameter int NUM_QUEUES  = sqrd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqrd_pkg::QUEUE_DEPTH_DEF,
  parameter int ID_WIDTH    = sqrd_pkg::ID_WIDTH_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // Request stream
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // [15:0] request_id, [17:16] queue_sel, [23:18] zero
  input  wire logic [sqrd_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [0] mode
  input  wire logic [sqrd_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  // Result stream
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // [1:0] queue_index, [17:2] request_out, [22:18] remaining, [23] zero
  output logic      [sqrd_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // [2:0] status
  output logic      [sqrd_pkg::M_TUSER_W-1:0]   m_axis_tuser_o,
  // Configuration port
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [sqrd_pkg::PADDR_W-1:0]     paddr,
  input  wire logic [sqrd_pkg::PDATA_W-1:0]     pwdata,
  output logic      [sqrd_pkg::PDATA_W-1:0]     prdata,
  output logic                                  pready
);

  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QW      = $clog2(NUM_QUEUES);
  localparam int ENTRIES = NUM_QUEUES * QUEUE_DEPTH;
  localparam int AW      = $clog2(ENTRIES);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  // Control state
  logic                          state_q, state_d;
  logic [sqrd_pkg::QIU_W-1:0]    qiu_q, qiu_d;
  logic [PTR_W-1:0]              head_q [NUM_QUEUES];
  logic [PTR_W-1:0]              head_d [NUM_QUEUES];
  logic [PTR_W-1:0]              tail_q [NUM_QUEUES];
  logic [PTR_W-1:0]              tail_d [NUM_QUEUES];
  logic [CNT_W-1:0]              count_q [NUM_QUEUES];
  logic [CNT_W-1:0]              count_d [NUM_QUEUES];
  logic                          pend_v_q, pend_v_d;
  logic                          out_v_q, out_v_d;

  // Result payload
  logic [sqrd_pkg::STATUS_W-1:0] pend_status_q, pend_status_d;
  logic [sqrd_pkg::QIDX_W-1:0]   pend_qidx_q, pend_qidx_d;
  logic [sqrd_pkg::REQ_W-1:0]    pend_req_q, pend_req_d;
  logic [sqrd_pkg::REM_W-1:0]    pend_rem_q, pend_rem_d;
  logic [sqrd_pkg::STATUS_W-1:0] out_status_q, out_status_d;
  logic [sqrd_pkg::QIDX_W-1:0]   out_qidx_q, out_qidx_d;
  logic [sqrd_pkg::REQ_W-1:0]    out_req_q, out_req_d;
  logic [sqrd_pkg::REM_W-1:0]    out_rem_q, out_rem_d;

  // Request fields
  logic                          in_mode;
  logic [sqrd_pkg::REQ_W-1:0]    in_req;
  logic [sqrd_pkg::SEL_W-1:0]    in_sel;
  logic [QW-1:0]                 sel_idx;
  logic                          sel_ok;

  logic                          in_fire;
  logic                          out_free;
  logic                          cfg_wr;

  logic [NUM_QUEUES-1:0][CNT_W-1:0] count_vec;
  logic [QW-1:0]                 pick;
  logic                          all_full;

  logic                          ram_en;
  logic                          ram_we;
  logic [AW-1:0]                 ram_addr;
  logic [ID_WIDTH-1:0]           ram_wdata;
  logic [ID_WIDTH-1:0]           ram_rdata;

  // Unpack request
  assign in_mode = s_axis_tuser_i[0];
  assign in_req  = s_axis_tdata_i[sqrd_pkg::REQ_W-1:0];
  assign in_sel  = s_axis_tdata_i[sqrd_pkg::REQ_W +: sqrd_pkg::SEL_W];
  assign sel_ok  = (32'(in_sel) < NUM_QUEUES);
  assign sel_idx = QW'(in_sel);

  // Handshakes
  assign out_free        = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!pend_v_q || out_free);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  // Configuration access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == sqrd_pkg::REG_QUEUES_IN_USE);
  assign prdata = (paddr[2] == sqrd_pkg::REG_QUEUES_IN_USE) ?
                  sqrd_pkg::PDATA_W'(qiu_q) : '0;

  // Gather counts for the selection tree
  always_comb begin
    for (int q = 0; q < NUM_QUEUES; q++) begin
      count_vec[q] = count_q[q];
    end
  end

  sqrd_pick #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_pick (
    .count_i         (count_vec),
    .queues_in_use_i (qiu_q),
    .pick_o          (pick),
    .all_full_o      (all_full)
  );

  sqrd_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (ENTRIES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequence one request: update pointers, access RAM, stage the result
  always_comb begin
    state_d       = state_q;
    qiu_d         = cfg_wr ? pwdata[sqrd_pkg::QIU_W-1:0] : qiu_q;
    head_d        = head_q;
    tail_d        = tail_q;
    count_d       = count_q;
    pend_v_d      = pend_v_q;
    out_v_d       = out_v_q;
    pend_status_d = pend_status_q;
    pend_qidx_d   = pend_qidx_q;
    pend_req_d    = pend_req_q;
    pend_rem_d    = pend_rem_q;
    out_status_d  = out_status_q;
    out_qidx_d    = out_qidx_q;
    out_req_d     = out_req_q;
    out_rem_d     = out_rem_q;
    ram_en        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = AW'(pick) * AW'(QUEUE_DEPTH) + AW'(tail_q[pick]);
    ram_wdata     = ID_WIDTH'(in_req);

    // Advance the staged result to the output register
    if (pend_v_q && out_free) begin
      out_v_d      = 1'b1;
      pend_v_d     = 1'b0;
      out_status_d = pend_status_q;
      out_qidx_d   = pend_qidx_q;
      out_req_d    = pend_req_q;
      out_rem_d    = pend_rem_q;
    end else if (m_axis_tready_i) begin
      out_v_d = 1'b0;
    end

    // Capture popped id from the RAM
    if (state_q == ST_READ) begin
      pend_req_d    = sqrd_pkg::REQ_W'(ram_rdata);
      pend_status_d = sqrd_pkg::ST_DEQUEUED;
      pend_v_d      = 1'b1;
      state_d       = ST_IDLE;
    end

    if (in_fire) begin
      pend_req_d = '0;
      if (in_mode == sqrd_pkg::MODE_ENQUEUE) begin
        pend_v_d = 1'b1;
        if (all_full) begin
          pend_status_d = sqrd_pkg::ST_ALL_FULL;
          pend_qidx_d   = '0;
          pend_rem_d    = '0;
        end else begin
          // Append to the tail of the chosen queue
          ram_en        = 1'b1;
          ram_we        = 1'b1;
          tail_d[pick]  = (tail_q[pick] == PTR_LAST) ? '0 : tail_q[pick] + 1'b1;
          count_d[pick] = count_q[pick] + 1'b1;
          pend_status_d = sqrd_pkg::ST_ENQUEUED;
          pend_qidx_d   = sqrd_pkg::QIDX_W'(pick);
          pend_rem_d    = sqrd_pkg::REM_W'(count_q[pick] + 1'b1);
        end
      end else begin
        pend_qidx_d = in_sel;
        pend_rem_d  = '0;
        if (!sel_ok) begin
          pend_v_d      = 1'b1;
          pend_status_d = sqrd_pkg::ST_BAD_QUEUE;
        end else if (count_q[sel_idx] == '0) begin
          pend_v_d      = 1'b1;
          pend_status_d = sqrd_pkg::ST_EMPTY;
        end else begin
          // Pop the head; data returns next cycle
          ram_en           = 1'b1;
          ram_addr         = AW'(sel_idx) * AW'(QUEUE_DEPTH) + AW'(head_q[sel_idx]);
          head_d[sel_idx]  = (head_q[sel_idx] == PTR_LAST) ? '0 : head_q[sel_idx] + 1'b1;
          count_d[sel_idx] = count_q[sel_idx] - 1'b1;
          pend_rem_d       = sqrd_pkg::REM_W'(count_q[sel_idx] - 1'b1);
          state_d          = ST_READ;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      qiu_q    <= sqrd_pkg::QIU_RESET;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      for (int q = 0; q < NUM_QUEUES; q++) begin
        head_q[q]  <= '0;
        tail_q[q]  <= '0;
        count_q[q] <= '0;
      end
    end else begin
      state_q  <= state_d;
      qiu_q    <= qiu_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pend_status_q <= pend_status_d;
    pend_qidx_q   <= pend_qidx_d;
    pend_req_q    <= pend_req_d;
    pend_rem_q    <= pend_rem_d;
    out_status_q  <= out_status_d;
    out_qidx_q    <= out_qidx_d;
    out_req_q     <= out_req_d;
    out_rem_q     <= out_rem_d;
  end

  // Pack result
  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {1'b0, out_rem_q, out_req_q, out_qidx_q};

endmodule

`default_nettype wire
